@@ src/vtpm_pkg.sv @@
// Shared types and constants for the voice table priority match unit.
// No dependencies; every other file in src/ uses this package.
package vtpm_pkg;

   // Request codes. Codes 6 and 7 carry no meaning and are served as failed finds.
   typedef enum logic [2:0] {
      REQ_APPEND    = 3'd0,
      REQ_MARK      = 3'd1,
      REQ_TRUNCATE  = 3'd2,
      REQ_SCORED    = 3'd3,
      REQ_EXCLUSIVE = 3'd4,
      REQ_DRUM      = 3'd5
   } req_kind_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FLUSH,
      S_FINISH
   } seq_state_type;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // Bank high byte from which a scored find may fall back to a drum match.
   localparam logic [7:0] DRUM_BANK_MIN = 8'd125;
   // Exclusive find compares the program on its low seven bits only.
   localparam int PROG_LOW_BITS = 7;

   typedef struct packed {
      req_kind_type req_type;
      logic [7:0]   bank_hi;
      logic [7:0]   bank_lo;
      logic [7:0]   program_req;
      logic [7:0]   entry_drum_note;
      logic         entry_is_fm;
      logic [7:0]   query_note;
   } vtpm_req_type;

   typedef struct packed {
      logic       found;
      logic [7:0] entry_index;
      logic       status;
      logic [8:0] entry_count;
   } vtpm_rsp_type;

   // One stored voice key, 33 bits.
   typedef struct packed {
      logic       is_fm;
      logic [7:0] msb;
      logic [7:0] lsb;
      logic [7:0] prog;
      logic [7:0] drum;
   } vtpm_entry_type;

   // Control from the sequencer to the match evaluator.
   typedef struct packed {
      logic         clear;
      logic         sample;
      req_kind_type mode;
   } vtpm_eval_ctl_type;

endpackage

@@ src/voice_table_priority_match_unit.sv @@
// Top level of the voice table priority match unit: sequencer, counts and response register.
// Depends on vtpm_pkg, vtpm_key_mem and vtpm_match_eval.
//
// Usage. A request word enters on req_valid/req_ready and exactly one response word
// leaves on rsp_valid/rsp_ready for each request, in order. Appends write the next free
// entry of the key memory; mark and truncate move the entry count against a saved
// baseline. The three finds walk the valid entries through the single read port of the
// key memory, one entry per cycle, forward for scored and drum finds and newest first
// for the exclusive find.
// Timing. A find over N > 0 valid entries reads them in the scan state, judges the last
// read in the flush state and forms the response word in the final step; append, mark,
// truncate, unused codes and finds on an empty table go straight to the final step. A
// new request is taken only once the response word of the one before has been loaded,
// so the unit does not take a request before it is through with the last.
// Reset clears the entry count, the baseline and all handshake state; memory contents
// are left as they are and never read before being written. While the receiver stalls,
// the response word waits in its register and a following request is still accepted and
// worked on; it holds in its final step until the response register is free.
module voice_table_priority_match_unit #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  vtpm_pkg::vtpm_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output vtpm_pkg::vtpm_rsp_type rsp_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   vtpm_pkg::seq_state_type state_ff, state_in;
   vtpm_pkg::vtpm_req_type  req_ff;
   logic [CNT_W-1:0]        valid_count_ff, valid_count_in;
   logic [CNT_W-1:0]        baseline_ff, baseline_in;
   logic [IDX_W-1:0]        addr_ff, addr_in;
   logic [CNT_W-1:0]        left_ff, left_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   vtpm_pkg::vtpm_rsp_type  rsp_data_ff, rsp_data_in;

   logic                       mem_rd_en;
   logic                       mem_wr_en;
   vtpm_pkg::vtpm_entry_type   mem_wr_data;
   vtpm_pkg::vtpm_entry_type   mem_rd_data;
   vtpm_pkg::vtpm_eval_ctl_type eval_ctl;
   logic                       eval_found;
   logic [IDX_W-1:0]           eval_idx;
   logic                       req_is_find;
   logic                       req_accept;

   assign req_accept = req_valid && req_ready;

   // The appended entry is built from the held request word.
   assign mem_wr_data = '{is_fm: req_ff.entry_is_fm, msb: req_ff.bank_hi,
                          lsb: req_ff.bank_lo, prog: req_ff.program_req,
                          drum: req_ff.entry_drum_note};

   // The memory is only written in the final step, after any scan has drained, so a
   // read and a write of the same entry never overlap and no forwarding is needed.
   vtpm_key_mem #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (IDX_W)
   ) u_key_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (valid_count_ff[IDX_W-1:0]),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (addr_ff),
      .rd_data (mem_rd_data)
   );

   vtpm_match_eval #(
      .IDX_W (IDX_W)
   ) u_match_eval (
      .clock     (clock),
      .reset     (reset),
      .ctl       (eval_ctl),
      .query     (req_ff),
      .entry     (mem_rd_data),
      .entry_idx (rd_idx_ff),
      .found     (eval_found),
      .found_idx (eval_idx)
   );

   always_comb begin
      req_is_find = (req_data.req_type == vtpm_pkg::REQ_SCORED) ||
                    (req_data.req_type == vtpm_pkg::REQ_EXCLUSIVE) ||
                    (req_data.req_type == vtpm_pkg::REQ_DRUM);

      state_in       = state_ff;
      req_ready      = 1'b0;
      addr_in        = addr_ff;
      left_in        = left_ff;
      rd_valid_in    = 1'b0;
      rd_idx_in      = rd_idx_ff;
      mem_rd_en      = 1'b0;
      mem_wr_en      = 1'b0;
      valid_count_in = valid_count_ff;
      baseline_in    = baseline_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      eval_ctl       = '{clear: 1'b0, sample: rd_valid_ff, mode: req_ff.req_type};

      unique case (state_ff)
         vtpm_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               eval_ctl.clear = 1'b1;
               if (req_is_find && (valid_count_ff != '0)) begin
                  state_in = vtpm_pkg::S_SCAN;
                  left_in  = valid_count_ff;
                  if (req_data.req_type == vtpm_pkg::REQ_EXCLUSIVE) begin
                     addr_in = IDX_W'(valid_count_ff - CNT_W'(1));
                  end else begin
                     addr_in = '0;
                  end
               end else begin
                  state_in = vtpm_pkg::S_FINISH;
               end
            end
         end
         vtpm_pkg::S_SCAN: begin
            mem_rd_en   = 1'b1;
            rd_valid_in = 1'b1;
            rd_idx_in   = addr_ff;
            left_in     = left_ff - CNT_W'(1);
            if (req_ff.req_type == vtpm_pkg::REQ_EXCLUSIVE) begin
               addr_in = addr_ff - IDX_W'(1);
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
            if (left_ff == CNT_W'(1)) begin
               state_in = vtpm_pkg::S_FLUSH;
            end
         end
         vtpm_pkg::S_FLUSH: begin
            // The last entry read is judged in this cycle.
            state_in = vtpm_pkg::S_FINISH;
         end
         vtpm_pkg::S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               state_in                = vtpm_pkg::S_IDLE;
               rsp_data_in             = '0;
               rsp_data_in.status      = vtpm_pkg::STATUS_OK;
               unique case (req_ff.req_type)
                  vtpm_pkg::REQ_APPEND: begin
                     if (valid_count_ff == CNT_W'(TABLE_DEPTH)) begin
                        rsp_data_in.status = vtpm_pkg::STATUS_FULL;
                     end else begin
                        mem_wr_en               = 1'b1;
                        rsp_data_in.found       = 1'b1;
                        rsp_data_in.entry_index = 8'(valid_count_ff);
                        valid_count_in          = valid_count_ff + CNT_W'(1);
                     end
                  end
                  vtpm_pkg::REQ_MARK: begin
                     baseline_in = valid_count_ff;
                  end
                  vtpm_pkg::REQ_TRUNCATE: begin
                     if (valid_count_ff > baseline_ff) begin
                        valid_count_in = baseline_ff;
                     end
                  end
                  vtpm_pkg::REQ_SCORED, vtpm_pkg::REQ_EXCLUSIVE, vtpm_pkg::REQ_DRUM: begin
                     rsp_data_in.found       = eval_found;
                     rsp_data_in.entry_index = 8'(eval_idx);
                  end
                  default: begin
                  end
               endcase
               rsp_data_in.entry_count = 9'(valid_count_in);
            end
         end
         default: begin
            state_in = vtpm_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= vtpm_pkg::S_IDLE;
         valid_count_ff <= '0;
         baseline_ff    <= '0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         valid_count_ff <= valid_count_in;
         baseline_ff    <= baseline_in;
         rd_valid_ff    <= rd_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_data;
      end
      addr_ff     <= addr_in;
      left_ff     <= left_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The entry count never runs past the table.
   assert property (@(posedge clock) disable iff (reset)
      valid_count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count exceeds table depth");

   // Truncate only lowers the count to the baseline, so the baseline never passes it.
   assert property (@(posedge clock) disable iff (reset)
      baseline_ff <= valid_count_ff)
      else $error("baseline above entry count");

   // Scans and appends never use the memory in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("memory read and write in the same cycle");

   // Read data is only judged while the scan pipeline is running.
   assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == vtpm_pkg::S_SCAN) || (state_ff == vtpm_pkg::S_FLUSH))
      else $error("entry judged outside a scan");

   // A response word only appears out of the final step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == vtpm_pkg::S_FINISH)
      else $error("response raised outside the final step");

endmodule

@@ src/vtpm_key_mem.sv @@
// Key memory: one write port and one read port with registered read data.
// Depends on vtpm_pkg for the entry type.
module vtpm_key_mem #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [ADDR_W-1:0]       wr_addr,
   input  vtpm_pkg::vtpm_entry_type wr_data,
   input  logic                    rd_en,
   input  logic [ADDR_W-1:0]       rd_addr,
   output vtpm_pkg::vtpm_entry_type rd_data
);

   vtpm_pkg::vtpm_entry_type key_store [DEPTH];
   vtpm_pkg::vtpm_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_store[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= key_store[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/vtpm_match_eval.sv @@
// Match evaluator: judges one entry per cycle and keeps the running winners of a scan.
// Depends on vtpm_pkg for the request, entry and control types.
module vtpm_match_eval #(
   parameter int IDX_W = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  vtpm_pkg::vtpm_eval_ctl_type ctl,
   input  vtpm_pkg::vtpm_req_type     query,
   input  vtpm_pkg::vtpm_entry_type   entry,
   input  logic [IDX_W-1:0]          entry_idx,
   output logic                      found,
   output logic [IDX_W-1:0]          found_idx
);

   localparam int PROG_LOW_BITS_M1 = vtpm_pkg::PROG_LOW_BITS - 1;

   // The score is the three-bit vector {bank high, bank low, drum} of match bits, so a
   // higher term always outweighs all lower ones together.
   logic             best_have_ff, best_have_in;
   logic [2:0]       best_score_ff, best_score_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic             fb_have_ff, fb_have_in;
   logic [IDX_W-1:0] fb_idx_ff, fb_idx_in;
   logic             hit_have_ff, hit_have_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             zero_have_ff, zero_have_in;
   logic [IDX_W-1:0] zero_idx_ff, zero_idx_in;

   logic       drum_eq;
   logic       drum_hit;
   logic       prog_ok;
   logic       excl_ok;
   logic [2:0] score;

   always_comb begin
      drum_eq  = entry.drum == query.query_note;
      drum_hit = entry.is_fm && (entry.drum != 8'd0) && drum_eq;
      prog_ok  = entry.is_fm && (entry.prog == query.program_req);
      excl_ok  = entry.is_fm && (entry.msb == query.bank_hi) &&
                 (entry.lsb == query.bank_lo) &&
                 (entry.prog[PROG_LOW_BITS_M1:0] == query.program_req[PROG_LOW_BITS_M1:0]);
      score    = {entry.msb == query.bank_hi, entry.lsb == query.bank_lo,
                  (entry.drum != 8'd0) && drum_eq};

      best_have_in  = best_have_ff;
      best_score_in = best_score_ff;
      best_idx_in   = best_idx_ff;
      fb_have_in    = fb_have_ff;
      fb_idx_in     = fb_idx_ff;
      hit_have_in   = hit_have_ff;
      hit_idx_in    = hit_idx_ff;
      zero_have_in  = zero_have_ff;
      zero_idx_in   = zero_idx_ff;

      if (ctl.clear) begin
         best_have_in = 1'b0;
         fb_have_in   = 1'b0;
         hit_have_in  = 1'b0;
         zero_have_in = 1'b0;
      end else if (ctl.sample) begin
         unique case (ctl.mode)
            vtpm_pkg::REQ_SCORED: begin
               if (prog_ok && (!best_have_ff || score > best_score_ff)) begin
                  best_have_in  = 1'b1;
                  best_score_in = score;
                  best_idx_in   = entry_idx;
               end
               if (drum_hit && !fb_have_ff) begin
                  fb_have_in = 1'b1;
                  fb_idx_in  = entry_idx;
               end
            end
            vtpm_pkg::REQ_EXCLUSIVE: begin
               if (excl_ok && drum_hit && !hit_have_ff) begin
                  hit_have_in = 1'b1;
                  hit_idx_in  = entry_idx;
               end
               if (excl_ok && (entry.drum == 8'd0) && !zero_have_ff) begin
                  zero_have_in = 1'b1;
                  zero_idx_in  = entry_idx;
               end
            end
            vtpm_pkg::REQ_DRUM: begin
               if (entry.is_fm && drum_eq && !hit_have_ff) begin
                  hit_have_in = 1'b1;
                  hit_idx_in  = entry_idx;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_have_ff <= 1'b0;
         fb_have_ff   <= 1'b0;
         hit_have_ff  <= 1'b0;
         zero_have_ff <= 1'b0;
      end else begin
         best_have_ff <= best_have_in;
         fb_have_ff   <= fb_have_in;
         hit_have_ff  <= hit_have_in;
         zero_have_ff <= zero_have_in;
      end
   end

   always_ff @(posedge clock) begin
      best_score_ff <= best_score_in;
      best_idx_ff   <= best_idx_in;
      fb_idx_ff     <= fb_idx_in;
      hit_idx_ff    <= hit_idx_in;
      zero_idx_ff   <= zero_idx_in;
   end

   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      unique case (ctl.mode)
         vtpm_pkg::REQ_SCORED: begin
            if (best_have_ff) begin
               found     = 1'b1;
               found_idx = best_idx_ff;
            end else if ((query.bank_hi >= vtpm_pkg::DRUM_BANK_MIN) && fb_have_ff) begin
               found     = 1'b1;
               found_idx = fb_idx_ff;
            end
         end
         vtpm_pkg::REQ_EXCLUSIVE: begin
            if (hit_have_ff) begin
               found     = 1'b1;
               found_idx = hit_idx_ff;
            end else if (zero_have_ff) begin
               found     = 1'b1;
               found_idx = zero_idx_ff;
            end
         end
         vtpm_pkg::REQ_DRUM: begin
            if (hit_have_ff) begin
               found     = 1'b1;
               found_idx = hit_idx_ff;
            end
         end
         default: begin
         end
      endcase
   end

endmodule
